>>> rtl/core/pmdq_pkg.sv
// Shared constants and types for the partitioned multi-deque core.
package pmdq_pkg;

  localparam int NUM_QUEUES      = 4;
  localparam int SLOTS_PER_QUEUE = 4;
  localparam int DATA_WIDTH      = 32;

  // Fixed port field widths
  localparam int OP_W   = 2;
  localparam int QSEL_W = 2;
  localparam int STAT_W = 2;
  localparam int WORD_W = 32;

  localparam int STORE_DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int QIDX_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int OFF_W       = $clog2(SLOTS_PER_QUEUE);
  localparam int CNT_W       = $clog2(SLOTS_PER_QUEUE + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // update indexes and access the store
  } dp_cmd_t;

endpackage

>>> rtl/core/pmdq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module pmdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pmdq_ctrl.sv
// Sequencer for the multi-deque core: accept, execute, respond.
module pmdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output pmdq_pkg::dp_cmd_t cmd
);
  import pmdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;
  logic   accept;

  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (accept) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r     <= S_RESP;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        S_RESP: begin
          out_valid_r <= 1'b0;
          if (accept) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

>>> rtl/core/pmdq_dp.sv
// Datapath: per-queue front/count registers, slot addressing and the slot store.
module pmdq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pmdq_pkg::dp_cmd_t                   cmd,
  input  logic [pmdq_pkg::OP_W-1:0]           in_opcode,
  input  logic [pmdq_pkg::QSEL_W-1:0]         in_queue_select,
  input  logic signed [pmdq_pkg::WORD_W-1:0]  in_push_value,
  output logic [pmdq_pkg::STAT_W-1:0]         out_status,
  output logic signed [pmdq_pkg::WORD_W-1:0]  out_pop_value
);
  import pmdq_pkg::*;

  // Captured word
  op_t                   op_r;
  logic [QSEL_W-1:0]     qsel_r;
  logic [DATA_WIDTH-1:0] val_r;

  // Queue state
  logic [OFF_W-1:0] front_r [NUM_QUEUES];
  logic [CNT_W-1:0] cnt_r   [NUM_QUEUES];

  // Result
  status_t status_r, status_nxt;
  logic    pop_ok_r, pop_ok_nxt;

  logic [QIDX_W-1:0] q_idx;
  logic              q_ok;
  logic [OFF_W-1:0]  cur_fr, fr_dec, fr_inc, rear_wr, rear_rd, off;
  logic [CNT_W-1:0]  cur_cnt;
  logic [OFF_W-1:0]  front_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              full, empty, upd, we, re;
  logic [ADDR_W-1:0] addr;
  logic [DATA_WIDTH-1:0] rdata;

  function automatic logic [OFF_W-1:0] wrap_off(input logic [OFF_W:0] s);
    logic [OFF_W:0] w;
    w = (s >= (OFF_W+1)'(SLOTS_PER_QUEUE)) ? s - (OFF_W+1)'(SLOTS_PER_QUEUE) : s;
    return w[OFF_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_opcode);
      qsel_r <= in_queue_select;
      val_r  <= DATA_WIDTH'($unsigned(in_push_value));
    end
  end

  assign q_idx   = QIDX_W'(qsel_r);
  assign q_ok    = (32'(qsel_r) < NUM_QUEUES);
  assign cur_fr  = front_r[q_idx];
  assign cur_cnt = cnt_r[q_idx];
  assign full    = (cur_cnt == CNT_W'(SLOTS_PER_QUEUE));
  assign empty   = (cur_cnt == '0);

  assign fr_dec  = (cur_fr == '0) ? OFF_W'(SLOTS_PER_QUEUE - 1) : cur_fr - 1'b1;
  assign fr_inc  = (cur_fr == OFF_W'(SLOTS_PER_QUEUE - 1)) ? '0 : cur_fr + 1'b1;
  assign rear_wr = wrap_off({1'b0, cur_fr} + (OFF_W+1)'(cur_cnt));
  assign rear_rd = wrap_off({1'b0, cur_fr} + (OFF_W+1)'(cur_cnt) - 1'b1);

  always_comb begin
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    upd        = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    off        = cur_fr;
    front_nxt  = cur_fr;
    cnt_nxt    = cur_cnt;
    unique case (op_r)
      OP_PUSH_FRONT: begin
        if (!q_ok || full) begin
          status_nxt = ST_FULL;
        end else begin
          upd       = 1'b1;
          we        = 1'b1;
          off       = fr_dec;
          front_nxt = fr_dec;
          cnt_nxt   = cur_cnt + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (!q_ok || full) begin
          status_nxt = ST_FULL;
        end else begin
          upd     = 1'b1;
          we      = 1'b1;
          off     = rear_wr;
          cnt_nxt = cur_cnt + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (!q_ok || empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          upd        = 1'b1;
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
          off        = cur_fr;
          front_nxt  = fr_inc;
          cnt_nxt    = cur_cnt - 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (!q_ok || empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          upd        = 1'b1;
          re         = 1'b1;
          pop_ok_nxt = 1'b1;
          off        = rear_rd;
          cnt_nxt    = cur_cnt - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Region base plus offset; multiply by a constant
  assign addr = ADDR_W'(ADDR_W'(q_idx) * ADDR_W'(SLOTS_PER_QUEUE)) + ADDR_W'(off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        front_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else if (cmd.exec && upd) begin
      front_r[q_idx] <= front_nxt;
      cnt_r[q_idx]   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  pmdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec & we),
    .waddr (addr),
    .wdata (val_r),
    .re    (cmd.exec & re),
    .raddr (addr),
    .rdata (rdata)
  );

  assign out_status    = status_r;
  assign out_pop_value = pop_ok_r ? WORD_W'(rdata) : '0;

endmodule

>>> rtl/core/partitioned_multi_deque_core.sv
// Top level: four circular deques sharing one slot store.
// A word is taken in IDLE or RESP; EXEC updates the indexes and accesses the store, and
//   its result is on the out_ ports during RESP, from the registered store read.
// busy is high while a word is in EXEC; a new word may be taken in the result cycle.
// Reset (rst_n low, synchronous): all queues empty, fronts at zero, no result
//   pending. Store contents are not cleared; only written slots are ever read.
module partitioned_multi_deque_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command input channel
  input  logic                                start,
  output logic                                busy,
  input  logic [pmdq_pkg::OP_W-1:0]           in_opcode,
  input  logic [pmdq_pkg::QSEL_W-1:0]         in_queue_select,
  input  logic signed [pmdq_pkg::WORD_W-1:0]  in_push_value,
  // Result channel: out_valid strobes for one cycle, no back-pressure
  output logic                                out_valid,
  output logic [pmdq_pkg::STAT_W-1:0]         out_status,
  output logic signed [pmdq_pkg::WORD_W-1:0]  out_pop_value
);
  import pmdq_pkg::*;

  dp_cmd_t cmd;

  // Sequencer: IDLE -> EXEC -> RESP, with RESP able to start the next word
  pmdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: status is decided and the store accessed in EXEC; the popped
  // word leaves the store's read register during RESP.
  pmdq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_queue_select (in_queue_select),
    .in_push_value   (in_push_value),
    .out_status      (out_status),
    .out_pop_value   (out_pop_value)
  );

endmodule

>>> tb/deque_checker.sv
// Checker for the partitioned multi-deque core: shadow deques, expected-result queue, compare.
`timescale 1ns / 100ps

module deque_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [pmdq_pkg::OP_W-1:0]           in_opcode,
  input  logic [pmdq_pkg::QSEL_W-1:0]         in_queue_select,
  input  logic signed [pmdq_pkg::WORD_W-1:0]  in_push_value,
  input  logic                                out_valid,
  input  logic [pmdq_pkg::STAT_W-1:0]         out_status,
  input  logic signed [pmdq_pkg::WORD_W-1:0]  out_pop_value,
  output int                                  fail_count,
  output int                                  replies_pending,
  output int                                  words_taken,
  output int                                  replies_checked,
  output int                                  full_seen,
  output int                                  empty_seen
);
  import pmdq_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [WORD_W-1:0]     word;
  } deque_reply_t;

  // shadow copy of the deques
  logic [WORD_W-1:0] slot_mem  [STORE_DEPTH];
  logic [OFF_W-1:0]  front_idx [NUM_QUEUES];
  logic [CNT_W-1:0]  fill_cnt  [NUM_QUEUES];

  deque_reply_t replies_due [$];
  int err_cnt, taken_cnt, checked_cnt, full_cnt, empty_cnt;

  // apply one word to the shadow deques, return the reply it should produce
  function automatic deque_reply_t deque_apply(op_t op, logic [QSEL_W-1:0] q,
                                               logic [WORD_W-1:0] w);
    deque_reply_t r;
    int cnt, fr, base;
    bit is_push;
    r.status = ST_OK;
    r.word   = '0;
    is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
    if (int'(q) >= NUM_QUEUES) begin
      r.status = is_push ? ST_FULL : ST_EMPTY;
      return r;
    end
    cnt  = fill_cnt[q];
    fr   = front_idx[q];
    base = int'(q) * SLOTS_PER_QUEUE;
    if (is_push && cnt >= SLOTS_PER_QUEUE) begin
      r.status = ST_FULL;
    end else if (!is_push && cnt == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (op)
        OP_PUSH_FRONT: begin
          fr = (fr + SLOTS_PER_QUEUE - 1) % SLOTS_PER_QUEUE;
          slot_mem[base + fr] = w;
          front_idx[q] = OFF_W'(fr);
          fill_cnt[q]  = CNT_W'(cnt + 1);
        end
        OP_PUSH_REAR: begin
          slot_mem[base + (fr + cnt) % SLOTS_PER_QUEUE] = w;
          fill_cnt[q] = CNT_W'(cnt + 1);
        end
        OP_POP_FRONT: begin
          r.word = slot_mem[base + fr];
          front_idx[q] = OFF_W'((fr + 1) % SLOTS_PER_QUEUE);
          fill_cnt[q]  = CNT_W'(cnt - 1);
        end
        default: begin
          r.word = slot_mem[base + (fr + cnt - 1) % SLOTS_PER_QUEUE];
          fill_cnt[q] = CNT_W'(cnt - 1);
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    deque_reply_t due;
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        front_idx[i] = '0;
        fill_cnt[i]  = '0;
      end
      replies_due.delete();
    end else begin
      // result first: a result passes through EXEC and is registered, so it never belongs
      // to the word taken at this same edge
      if ($isunknown(out_valid)) begin
        $display("%0t ns: out_valid unknown, expected 0 or 1, got %b", $time, out_valid);
        err_cnt++;
      end else if (out_valid) begin
        if (replies_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got status %0d word %h",
                   $time, out_status, out_pop_value);
          err_cnt++;
        end else begin
          due = replies_due.pop_front();
          checked_cnt++;
          if (due.status == ST_FULL)  full_cnt++;
          if (due.status == ST_EMPTY) empty_cnt++;
          if (out_status !== due.status) begin
            $display("%0t ns: status mismatch, expected %0d, got %0d",
                     $time, due.status, out_status);
            err_cnt++;
          end
          if (out_pop_value !== due.word) begin
            $display("%0t ns: pop word mismatch, expected %h, got %h",
                     $time, due.word, out_pop_value);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        replies_due.push_back(deque_apply(op_t'(in_opcode), in_queue_select, in_push_value));
        taken_cnt++;
      end
    end
    fail_count      <= err_cnt;
    replies_pending <= replies_due.size();
    words_taken     <= taken_cnt;
    replies_checked <= checked_cnt;
    full_seen       <= full_cnt;
    empty_seen      <= empty_cnt;
  end

endmodule

>>> tb/testbench.sv
// Top of the deque core testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import pmdq_pkg::*;

  // The limit leaves a wide margin for the ~1100 words and their sender gaps.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_WORDS  = 275;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int SETTLE_CYCLES = 4;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [OP_W-1:0]           in_opcode;
  logic [QSEL_W-1:0]         in_queue_select;
  logic signed [WORD_W-1:0]  in_push_value;
  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic signed [WORD_W-1:0]  out_pop_value;

  int fail_count, replies_pending, words_taken, replies_checked, full_seen, empty_seen;
  int cycle_cnt = 0;
  int idle_pct;   // chance in percent that the sender idles before a word

  partitioned_multi_deque_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_queue_select (in_queue_select),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pop_value   (out_pop_value)
  );

  deque_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_queue_select (in_queue_select),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_pop_value   (out_pop_value),
    .fail_count      (fail_count),
    .replies_pending (replies_pending),
    .words_taken     (words_taken),
    .replies_checked (replies_checked),
    .full_seen       (full_seen),
    .empty_seen      (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, independent of the stimulus thread
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive one word at a falling edge, keep start high until the word is
  // taken at a rising edge with busy low. Optional sender gaps come first,
  // one start assignment per falling edge.
  task automatic send_word(input op_t op, input logic [QSEL_W-1:0] q,
                           input logic [WORD_W-1:0] w);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_queue_select <= q;
    in_push_value   <= w;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int phase_idle [4];
    int push_bias;
    int drain;
    op_t op;
    logic [WORD_W-1:0] w;

    // phase 2 stands for the receiver-stall phase; the result side has no
    // back-pressure, so it runs without sender gaps
    phase_idle = '{0, 75, 0, 15};
    idle_pct        = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_PUSH_FRONT;
    in_queue_select = '0;
    in_push_value   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // pops on empty queues
    send_word(OP_POP_FRONT, 2'd0, 32'h1234_5678);
    send_word(OP_POP_REAR,  2'd1, '0);
    // fill queue 0 from the rear with the word extremes, then refuse both pushes
    send_word(OP_PUSH_REAR, 2'd0, 32'h7FFF_FFFF);
    send_word(OP_PUSH_REAR, 2'd0, 32'h8000_0000);
    send_word(OP_PUSH_REAR, 2'd0, 32'h0000_0000);
    send_word(OP_PUSH_REAR, 2'd0, 32'hFFFF_FFFF);
    send_word(OP_PUSH_FRONT, 2'd0, 32'hDEAD_BEEF);
    send_word(OP_PUSH_REAR,  2'd0, 32'hDEAD_BEEF);
    send_word(OP_POP_REAR,   2'd0, '0);
    send_word(OP_POP_FRONT,  2'd0, '0);
    // push front wraps the front index below zero
    send_word(OP_PUSH_FRONT, 2'd1, 32'hA5A5_A5A5);
    send_word(OP_PUSH_FRONT, 2'd1, 32'h5A5A_5A5A);
    send_word(OP_PUSH_REAR,  2'd1, 32'h0000_0001);
    send_word(OP_POP_REAR,   2'd1, '0);
    send_word(OP_POP_REAR,   2'd1, '0);
    send_word(OP_POP_FRONT,  2'd1, '0);
    send_word(OP_POP_FRONT,  2'd1, '0);
    // last two queues, mixed ends
    send_word(OP_PUSH_REAR,  2'd2, 32'h0F0F_0F0F);
    send_word(OP_POP_FRONT,  2'd2, '0);
    send_word(OP_PUSH_FRONT, 2'd3, 32'hF0F0_F0F0);
    send_word(OP_POP_REAR,   2'd3, '0);
    send_word(OP_POP_FRONT,  2'd3, '0);

    // --- random part ---
    // push bias is redrawn every 32 words so queues swing between empty and full
    push_bias = 50;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 32 == 0) begin
          case ($urandom_range(0, 2))
            0:       push_bias = 25;
            1:       push_bias = 50;
            default: push_bias = 75;
          endcase
        end
        if ($urandom_range(0, 99) < push_bias)
          op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        else
          op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
        case ($urandom_range(0, 11))
          0:       w = 32'h0000_0000;
          1:       w = 32'hFFFF_FFFF;
          2:       w = 32'h7FFF_FFFF;
          3:       w = 32'h8000_0000;
          default: w = $urandom;
        endcase
        send_word(op, QSEL_W'($urandom_range(0, NUM_QUEUES - 1)), w);
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // drain the outstanding results, then let the pipe settle
    drain = 0;
    while (replies_pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words over four sender-gap phases; %0d results checked",
             words_taken, replies_checked);
    $display("refusals seen: %0d on full queues, %0d on empty queues", full_seen, empty_seen);
    if (replies_pending != 0)
      $display("%0t ns: %0d results never arrived", $time, replies_pending);
    if (fail_count == 0 && replies_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
